[hdl/rational_exponent_alu_core_macros.svh]
// assertion macros shared by the rational exponent unit
// expects clk and rst_n in the scope of each use
`ifndef RATIONAL_EXPONENT_ALU_CORE_MACROS_SVH
`define RATIONAL_EXPONENT_ALU_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define REA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define REA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rea_pkg.sv]
// rea_pkg: widths, mode codes and unit request/response types
// of the rational exponent unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rea_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int MAG_W     = IN_WIDTH;
  localparam int PROD_W    = 2 * IN_WIDTH;
  localparam int NUM_W     = PROD_W + 1;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;
  localparam int NUM_EXT_W = (NUM_W > RES_NUM_W) ? NUM_W : RES_NUM_W;
  localparam int DEN_EXT_W = (NUM_W > RES_DEN_W) ? NUM_W : RES_DEN_W;
  localparam int SHIFT_W   = $clog2(NUM_W);
  localparam int CNT_W     = $clog2(NUM_W + 1);

  localparam logic [1:0] MODE_NORM = 2'd0;
  localparam logic [1:0] MODE_POW  = 2'd1;
  localparam logic [1:0] MODE_SUM  = 2'd2;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [NUM_W-1:0]  wide_t;

  typedef struct packed {
    logic  start;
    wide_t u;
    wide_t v;
  } gcd_req_t;

  typedef struct packed {
    logic  done;
    wide_t g;
  } gcd_rsp_t;

  typedef struct packed {
    logic  start;
    wide_t dividend;
    wide_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    wide_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/rea_mul.sv]
// rea_mul: registered unsigned magnitude multiplier, one product per cycle
// depends on rea_pkg
`timescale 1ns / 1ps
`default_nettype none

module rea_mul (
  input  wire logic         clk,
  input  wire rea_pkg::mag_t  a_i,
  input  wire rea_pkg::mag_t  b_i,
  output rea_pkg::prod_t      p_o
);

  rea_pkg::prod_t p_r;

  always_ff @(posedge clk) begin
    p_r <= rea_pkg::prod_t'(a_i) * rea_pkg::prod_t'(b_i);
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

[hdl/rea_gcd.sv]
// rea_gcd: binary gcd, one shift or one subtract per cycle
// depends on rea_pkg; both operands must be nonzero at start
`timescale 1ns / 1ps
`default_nettype none

module rea_gcd (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rea_pkg::gcd_req_t req_i,
  output rea_pkg::gcd_rsp_t      rsp_o
);

  logic                         busy_r;
  logic                         done_r;
  rea_pkg::wide_t               u_r;
  rea_pkg::wide_t               v_r;
  rea_pkg::wide_t               g_r;
  logic [rea_pkg::SHIFT_W-1:0]  k_r;
  logic                         u_gt_v;
  rea_pkg::wide_t               diff;

  // the one compare and subtract shared by both operands
  assign u_gt_v = (u_r > v_r);
  assign diff   = u_gt_v ? (u_r - v_r) : (v_r - u_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && u_r[0] && v_r[0] && (u_r == v_r)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      u_r <= req_i.u;
      v_r <= req_i.v;
      k_r <= '0;
    end else if (busy_r) begin
      if (!u_r[0] && !v_r[0]) begin
        // common factor of two
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + rea_pkg::SHIFT_W'(1);
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r == v_r) begin
        g_r <= u_r << k_r;
      end else if (u_gt_v) begin
        u_r <= diff;
      end else begin
        v_r <= diff;
      end
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.g    = g_r;

endmodule

`default_nettype wire

[hdl/rea_divu.sv]
// rea_divu: restoring unsigned divider, one quotient bit per cycle
// depends on rea_pkg; divisor must be nonzero
`timescale 1ns / 1ps
`default_nettype none

module rea_divu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rea_pkg::div_req_t req_i,
  output rea_pkg::div_rsp_t      rsp_o
);

  logic                       busy_r;
  logic                       done_r;
  logic [rea_pkg::CNT_W-1:0]  cnt_r;
  logic [rea_pkg::NUM_W:0]    rem_r;
  rea_pkg::wide_t             quo_r;
  rea_pkg::wide_t             dvs_r;
  logic [rea_pkg::NUM_W:0]    rem_sh;
  logic [rea_pkg::NUM_W:0]    dvs_ext;
  logic                       fits;

  assign rem_sh  = {rem_r[rea_pkg::NUM_W-1:0], quo_r[rea_pkg::NUM_W-1]};
  assign dvs_ext = {1'b0, dvs_r};
  assign fits    = (rem_sh >= dvs_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= rea_pkg::CNT_W'(rea_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - rea_pkg::CNT_W'(1);
        if (cnt_r == rea_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r <= '0;
      quo_r <= req_i.dividend;
      dvs_r <= req_i.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - dvs_ext) : rem_sh;
      quo_r <= {quo_r[rea_pkg::NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = quo_r;

endmodule

`default_nettype wire

[hdl/rational_exponent_alu_core.sv]
// rational_exponent_alu_core: top level of the rational exponent unit
// depends on rea_pkg, rea_mul, rea_gcd, rea_divu and the assertion macros
//
// usage:
//   input channel in_valid/in_stall carries mode and two fractions a and b;
//   mode 0 (and 3) reduces a, mode 1 multiplies a by b, mode 2 adds them.
//   result channel out_valid/out_stall returns one reduced fraction per
//   transaction, with out_status set and both fraction fields zero when a
//   denominator in use is zero.
//   one transaction is processed at a time: in_stall is high from the cycle
//   after acceptance until the result is loaded into the output register.
//   a zero-denominator error goes straight to the final state; otherwise power
//   and sum first step through the multiply states, then the numerator is
//   checked and a zero numerator goes to the final state; any other result
//   runs the binary gcd (one shift or subtract per step), then the numerator
//   and denominator divides, and the gcd loop and divides set the duration.
//   a finished result waits in the output register while out_stall is high;
//   the next transaction may be accepted meanwhile and its result waits in
//   the final state until the register frees up.
//   reset (rst_n low, synchronous) returns to idle and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_exponent_alu_core_macros.svh"

module rational_exponent_alu_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_mode,
  input  wire logic signed [rea_pkg::IN_WIDTH-1:0]  in_a_num,
  input  wire logic signed [rea_pkg::IN_WIDTH-1:0]  in_a_den,
  input  wire logic signed [rea_pkg::IN_WIDTH-1:0]  in_b_num,
  input  wire logic signed [rea_pkg::IN_WIDTH-1:0]  in_b_den,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [rea_pkg::RES_NUM_W-1:0]      out_res_num,
  output logic [rea_pkg::RES_DEN_W-1:0]             out_res_den,
  output logic                                      out_status
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CHK,
    ST_GCD,
    ST_DIVN_GO,
    ST_DIVN,
    ST_DIVD_GO,
    ST_DIVD,
    ST_DONE
  } state_t;

  function automatic rea_pkg::mag_t mag_of(input logic [rea_pkg::IN_WIDTH-1:0] v);
    return v[rea_pkg::IN_WIDTH-1] ? (rea_pkg::mag_t'(~v) + rea_pkg::mag_t'(1))
                                  : rea_pkg::mag_t'(v);
  endfunction

  state_t                          state_r;
  logic                            out_valid_r;
  logic signed [rea_pkg::RES_NUM_W-1:0] res_num_r;
  logic [rea_pkg::RES_DEN_W-1:0]   res_den_r;
  logic                            status_r;

  logic [1:0]                      mode_r;
  logic                            err_r;
  logic                            an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  rea_pkg::mag_t                   an_m_r, ad_m_r, bn_m_r, bd_m_r;
  rea_pkg::prod_t                  t1_r;
  rea_pkg::wide_t                  num_mag_r, den_mag_r, g_r, nm_r, dm_r;
  logic                            num_neg_r;

  logic                            accept;
  logic                            in_err;
  logic                            is_two_op;
  logic                            out_free;
  rea_pkg::mag_t                   mul_a, mul_b;
  rea_pkg::prod_t                  mul_p;
  logic                            x_neg, y_neg;
  rea_pkg::wide_t                  sum_mag;
  logic                            sum_neg;
  rea_pkg::gcd_req_t               gcd_req;
  rea_pkg::gcd_rsp_t               gcd_rsp;
  rea_pkg::div_req_t               div_req;
  rea_pkg::div_rsp_t               div_rsp;
  logic                            res_neg;
  logic [rea_pkg::NUM_EXT_W-1:0]   nm_ext, nm_signed;
  logic [rea_pkg::DEN_EXT_W-1:0]   dm_ext;
  logic                            fields_zero;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign is_two_op = (in_mode == rea_pkg::MODE_POW) || (in_mode == rea_pkg::MODE_SUM);
  assign in_err    = (in_a_den == '0) || (is_two_op && (in_b_den == '0));
  assign out_free  = !out_valid_r || !out_stall;

  // operand schedule: ad*bd, then an*bn or an*bd, then bn*ad
  always_comb begin
    unique case (state_r)
      ST_MUL0: begin
        mul_a = ad_m_r;
        mul_b = bd_m_r;
      end
      ST_MUL1: begin
        mul_a = an_m_r;
        mul_b = (mode_r == rea_pkg::MODE_POW) ? bn_m_r : bd_m_r;
      end
      default: begin
        mul_a = bn_m_r;
        mul_b = ad_m_r;
      end
    endcase
  end

  rea_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // signed-magnitude add of an*bd and bn*ad
  assign x_neg = an_neg_r ^ bd_neg_r;
  assign y_neg = bn_neg_r ^ ad_neg_r;
  always_comb begin
    if (x_neg == y_neg) begin
      sum_mag = rea_pkg::wide_t'(t1_r) + rea_pkg::wide_t'(mul_p);
      sum_neg = x_neg;
    end else if (t1_r >= mul_p) begin
      sum_mag = rea_pkg::wide_t'(t1_r - mul_p);
      sum_neg = x_neg;
    end else begin
      sum_mag = rea_pkg::wide_t'(mul_p - t1_r);
      sum_neg = y_neg;
    end
  end

  assign gcd_req.start = (state_r == ST_CHK) && (num_mag_r != '0);
  assign gcd_req.u     = num_mag_r;
  assign gcd_req.v     = den_mag_r;

  rea_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (gcd_req),
    .rsp_o (gcd_rsp)
  );

  assign div_req.start    = (state_r == ST_DIVN_GO) || (state_r == ST_DIVD_GO);
  assign div_req.dividend = (state_r == ST_DIVD_GO) ? den_mag_r : num_mag_r;
  assign div_req.divisor  = g_r;

  rea_divu u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign res_neg   = (nm_r != '0) && (num_neg_r != (ad_neg_r ^ (bd_neg_r &&
                     ((mode_r == rea_pkg::MODE_POW) || (mode_r == rea_pkg::MODE_SUM)))));
  assign nm_ext    = rea_pkg::NUM_EXT_W'(nm_r);
  assign nm_signed = res_neg ? (~nm_ext + rea_pkg::NUM_EXT_W'(1)) : nm_ext;
  assign dm_ext    = rea_pkg::DEN_EXT_W'(dm_r);

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      err_r     <= in_err;
      an_neg_r  <= in_a_num[rea_pkg::IN_WIDTH-1];
      ad_neg_r  <= in_a_den[rea_pkg::IN_WIDTH-1];
      bn_neg_r  <= in_b_num[rea_pkg::IN_WIDTH-1];
      bd_neg_r  <= in_b_den[rea_pkg::IN_WIDTH-1];
      an_m_r    <= mag_of(in_a_num);
      ad_m_r    <= mag_of(in_a_den);
      bn_m_r    <= mag_of(in_b_num);
      bd_m_r    <= mag_of(in_b_den);
      num_mag_r <= rea_pkg::wide_t'(mag_of(in_a_num));
      den_mag_r <= rea_pkg::wide_t'(mag_of(in_a_den));
      num_neg_r <= in_a_num[rea_pkg::IN_WIDTH-1];
    end
    case (state_r)
      ST_MUL1: den_mag_r <= rea_pkg::wide_t'(mul_p);
      ST_MUL2: begin
        t1_r <= mul_p;
        if (mode_r == rea_pkg::MODE_POW) begin
          num_mag_r <= rea_pkg::wide_t'(mul_p);
          num_neg_r <= an_neg_r ^ bn_neg_r;
        end
      end
      ST_MUL3: begin
        num_mag_r <= sum_mag;
        num_neg_r <= sum_neg;
      end
      ST_CHK: begin
        // zero numerator reduces to 0/1
        nm_r <= '0;
        dm_r <= rea_pkg::wide_t'(1);
      end
      ST_GCD:  if (gcd_rsp.done) g_r  <= gcd_rsp.g;
      ST_DIVN: if (div_rsp.done) nm_r <= div_rsp.quotient;
      ST_DIVD: if (div_rsp.done) dm_r <= div_rsp.quotient;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_err) begin
              state_r <= ST_DONE;
            end else if (is_two_op) begin
              state_r <= ST_MUL0;
            end else begin
              state_r <= ST_CHK;
            end
          end
        end
        ST_MUL0: state_r <= ST_MUL1;
        ST_MUL1: state_r <= ST_MUL2;
        ST_MUL2: state_r <= (mode_r == rea_pkg::MODE_POW) ? ST_CHK : ST_MUL3;
        ST_MUL3: state_r <= ST_CHK;
        ST_CHK:  state_r <= (num_mag_r != '0) ? ST_GCD : ST_DONE;
        ST_GCD:     if (gcd_rsp.done) state_r <= ST_DIVN_GO;
        ST_DIVN_GO: state_r <= ST_DIVN;
        ST_DIVN:    if (div_rsp.done) state_r <= ST_DIVD_GO;
        ST_DIVD_GO: state_r <= ST_DIVD;
        ST_DIVD:    if (div_rsp.done) state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r     <= ST_IDLE;
            if (err_r) begin
              res_num_r <= '0;
              res_den_r <= '0;
              status_r  <= 1'b1;
            end else begin
              res_num_r <= nm_signed[rea_pkg::RES_NUM_W-1:0];
              res_den_r <= dm_ext[rea_pkg::RES_DEN_W-1:0];
              status_r  <= 1'b0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = status_r;

  assign fields_zero = (out_res_num == '0) && (out_res_den == '0);

  `REA_ASSERT_NXT(a_busy_after_accept, accept, state_r != ST_IDLE, "accept left the unit idle")
  `REA_ASSERT_IMP(a_err_zero_fields, out_valid && out_status, fields_zero, "nonzero error fields")
  `REA_ASSERT_IMP(a_gcd_nonzero, gcd_rsp.done, gcd_rsp.g != '0, "gcd unit returned zero")

endmodule

`default_nettype wire
